// ----- rtl/srr_pkg.sv -----
// srr_pkg: shared constants, types and helper functions of the servo ramp regulator.
// No dependencies; the regulator, the checker and the testbench refer to it by scoped names.
package srr_pkg;

    localparam int NUM_SERVOS = 8;
    localparam int SRV_AW     = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

    localparam logic [15:0] ANGLE_MAX  = 16'd36000;
    localparam logic [16:0] FACTOR_ONE = 17'd65536;
    localparam logic [7:0]  DPS_MIN    = 8'd1;
    localparam logic [7:0]  DPS_MAX    = 8'd240;
    localparam logic [15:0] RECIP10    = 16'd52429;

    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic REG_SLICE = 1'b0;
    localparam logic [7:0] SLICE_RST = 8'd20;

    typedef struct packed {
        logic [15:0] cur;
        logic [15:0] tgt;
        logic [16:0] rf;
        logic [15:0] rate;
        logic [12:0] cs;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic logic [15:0] sat_angle(input logic [15:0] ang);
        return (ang > ANGLE_MAX) ? ANGLE_MAX : ang;
    endfunction

    // clamp to 1..240 deg/s, then floor(dps * 256 / 10) as Q5.8 hundredths per ms
    function automatic logic [12:0] cruise_of(input logic [9:0] dps);
        logic [7:0]  d;
        logic [31:0] p;
        if (dps < 10'(DPS_MIN)) begin
            d = DPS_MIN;
        end else if (dps > 10'(DPS_MAX)) begin
            d = DPS_MAX;
        end else begin
            d = dps[7:0];
        end
        p = 32'({d, 8'b0}) * 32'(RECIP10);
        return p[31:19];
    endfunction

endpackage

// ----- rtl/srr_if.sv -----
// srr_req_if / srr_res_if: valid-ready channels for command and result beats.
// No dependencies.
interface srr_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  servo_id;
    logic [15:0] target_angle;
    logic [9:0]  speed_dps;
    logic [15:0] ramp_step;

    modport source(output valid, cmd, servo_id, target_angle, speed_dps, ramp_step,
                   input ready);
    modport sink(input valid, cmd, servo_id, target_angle, speed_dps, ramp_step,
                 output ready);
endinterface

interface srr_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  servo_id_res;
    logic [15:0] position;

    modport source(output valid, servo_id_res, position, input ready);
    modport sink(input valid, servo_id_res, position, output ready);
endinterface

// ----- rtl/srr_ram.sv -----
// srr_ram: generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module srr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/servo_ramp_regulator.sv -----
// servo_ramp_regulator: per-servo ramp, speed rising with the square of the ramp factor,
// with state in one synchronous RAM. Depends on srr_pkg, srr_req_if / srr_res_if and srr_ram.
//
//  channel   dir   beat contents                                         handshake
//  i_req     in    cmd, servo_id, target_angle, speed_dps, ramp_step     valid/ready
//  o_res     out   servo_id_res, position                                valid/ready
//  apb       in    slice_ms at address 0                                 psel/penable
//
// A set is accepted, then read and written back in one state; a tick is accepted, then
// passes read and factor update, square, speed scale, step limit and write-back.
// One servo entry is in flight at a time, so the RAM needs no forwarding.
// Synchronous reset clears the per-entry valid bits; an unwritten entry reads as zero.
// A tick stalls in write-back while the output register holds an untaken beat.
module servo_ramp_regulator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    srr_req_if.sink          i_req,
    srr_res_if.source        o_res,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD   = 6'b000010,
        ST_SQ   = 6'b000100,
        ST_SC   = 6'b001000,
        ST_LIM  = 6'b010000,
        ST_WR   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [7:0]  r_slice;
    logic        r_cmd;
    logic [7:0]  r_id;
    logic [15:0] r_ang;
    logic [12:0] r_cs;
    logic [15:0] r_rate;
    srr_pkg::t_entry r_ent;
    logic [33:0] r_ff;
    logic [12:0] r_spd;
    logic [12:0] r_lim;
    logic [srr_pkg::NUM_SERVOS-1:0] r_vld;
    logic        r_ovld;
    logic [7:0]  r_oid;
    logic [15:0] r_opos;

    logic [srr_pkg::ENTRY_W-1:0] w_rdata;
    srr_pkg::t_entry w_ent, w_wdata;
    logic        w_acc, w_inrange, w_we, w_out_free;
    logic [srr_pkg::SRV_AW-1:0] w_idx;
    logic [23:0] w_inc;
    logic [24:0] w_sum;
    logic [16:0] w_f;
    logic        w_rev;
    logic [46:0] w_prod;
    logic [20:0] w_limp;
    logic [15:0] w_dist, w_step, w_new;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == srr_pkg::REG_SLICE) ? {24'b0, r_slice} : 32'b0;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_inrange   = {1'b0, i_req.servo_id} < 9'(srr_pkg::NUM_SERVOS);
    assign w_idx       = r_id[srr_pkg::SRV_AW-1:0];
    assign w_out_free  = !r_ovld || o_res.ready;

    srr_ram #(
        .WIDTH(srr_pkg::ENTRY_W),
        .DEPTH(srr_pkg::NUM_SERVOS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_idx),
        .i_wdata(w_wdata),
        .i_re   (w_acc),
        .i_raddr(i_req.servo_id[srr_pkg::SRV_AW-1:0]),
        .o_rdata(w_rdata)
    );

    always_comb begin
        w_ent  = r_vld[w_idx] ? srr_pkg::t_entry'(w_rdata) : '0;
        w_inc  = 24'(w_ent.rate) * 24'(r_slice);
        w_sum  = 25'(w_ent.rf) + 25'(w_inc);
        if (w_ent.rf >= srr_pkg::FACTOR_ONE) begin
            w_f = w_ent.rf;
        end else if (w_sum > 25'(srr_pkg::FACTOR_ONE)) begin
            w_f = srr_pkg::FACTOR_ONE;
        end else begin
            w_f = w_sum[16:0];
        end
        w_rev  = (w_ent.cur > w_ent.tgt) != (w_ent.cur > r_ang);
        w_prod = 47'(r_ent.cs) * 47'(r_ff);
        w_limp = 21'(r_spd) * 21'(r_slice);
        w_dist = (r_ent.tgt > r_ent.cur) ? (r_ent.tgt - r_ent.cur) : (r_ent.cur - r_ent.tgt);
        w_step = (16'(r_lim) < w_dist) ? 16'(r_lim) : w_dist;
        if (w_step == 16'd0) begin
            w_step = 16'd1;
        end
        w_new  = (r_ent.tgt < r_ent.cur) ? (r_ent.cur - w_step) : (r_ent.cur + w_step);
    end

    always_comb begin
        n_state = r_state;
        w_we    = 1'b0;
        w_wdata = r_ent;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc && w_inrange) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                if (r_cmd == srr_pkg::CMD_SET) begin
                    n_state = ST_IDLE;
                    if (w_ent.cur != r_ang) begin
                        w_we         = 1'b1;
                        w_wdata      = w_ent;
                        w_wdata.rf   = w_rev ? 17'd0 : w_ent.rf;
                        w_wdata.tgt  = r_ang;
                        w_wdata.rate = r_rate;
                        w_wdata.cs   = r_cs;
                    end
                end else if (w_ent.cur == w_ent.tgt) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_SQ;
                end
            end
            ST_SQ:  n_state = ST_SC;
            ST_SC:  n_state = ST_LIM;
            ST_LIM: n_state = ST_WR;
            ST_WR: begin
                if (w_out_free) begin
                    n_state     = ST_IDLE;
                    w_we        = 1'b1;
                    w_wdata.cur = w_new;
                    w_wdata.rf  = (w_new == r_ent.tgt) ? 17'd0 : r_ent.rf;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_slice <= srr_pkg::SLICE_RST;
            r_vld   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && pready && paddr[2] == srr_pkg::REG_SLICE) begin
                r_slice <= pwdata[7:0];
            end
            if (w_we) begin
                r_vld[w_idx] <= 1'b1;
            end
            if (r_state == ST_WR && w_out_free) begin
                r_ovld <= 1'b1;
            end else if (o_res.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cmd  <= i_req.cmd;
            r_id   <= i_req.servo_id;
            r_ang  <= srr_pkg::sat_angle(i_req.target_angle);
            r_cs   <= srr_pkg::cruise_of(i_req.speed_dps);
            r_rate <= i_req.ramp_step;
        end
        if (r_state == ST_RD) begin
            r_ent <= '{cur: w_ent.cur, tgt: w_ent.tgt, rf: w_f, rate: w_ent.rate,
                       cs: w_ent.cs};
        end
        if (r_state == ST_SQ) begin
            r_ff <= 34'(r_ent.rf) * 34'(r_ent.rf);
        end
        if (r_state == ST_SC) begin
            r_spd <= w_prod[44:32];
        end
        if (r_state == ST_LIM) begin
            r_lim <= w_limp[20:8];
        end
        if (r_state == ST_WR && w_out_free) begin
            r_oid  <= r_id;
            r_opos <= w_new;
        end
    end

    assign o_res.valid        = r_ovld;
    assign o_res.servo_id_res = r_oid;
    assign o_res.position     = r_opos;
endmodule

// ----- rtl/srr_chk.sv -----
// srr_chk: port-level checks on the servo ramp regulator, attached by bind.
// Depends on srr_pkg and the top level servo_ramp_regulator.
module srr_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic [7:0]  i_req_servo_id,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [7:0]  i_res_servo_id,
    input logic [15:0] i_res_position
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result beat dropped while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_res_position <= srr_pkg::ANGLE_MAX)
        else $error("position above full turn");

    a_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> {1'b0, i_res_servo_id} < 9'(srr_pkg::NUM_SERVOS))
        else $error("result for servo out of range");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && ({1'b0, i_req_servo_id} < 9'(srr_pkg::NUM_SERVOS))
        |=> !i_req_ready)
        else $error("new beat taken while servo entry in flight");

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !$rose(i_res_valid))
        else $error("result appeared before read-modify-write");
endmodule

bind servo_ramp_regulator srr_chk u_srr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_req_servo_id(i_req.servo_id),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_servo_id(o_res.servo_id_res),
    .i_res_position(o_res.position)
);

// ----- test/testbench.sv -----
// testbench: self-checking bench for servo_ramp_regulator; predicts every move beat per servo.
// Depends on srr_pkg, srr_req_if / srr_res_if and the servo_ramp_regulator RTL.
// Drives commands and slice settings, stalls both channels at random and checks each move.
module testbench;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  id;
        logic [15:0] angle;
        logic [9:0]  dps;
        logic [15:0] raise;
    } t_cmd_beat;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] pos;
    } t_move;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;

    srr_req_if req_ch();
    srr_res_if res_ch();

    servo_ramp_regulator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [15:0] srv_pos    [srr_pkg::NUM_SERVOS];
    logic [15:0] srv_goal   [srr_pkg::NUM_SERVOS];
    logic [16:0] srv_factor [srr_pkg::NUM_SERVOS];
    logic [15:0] srv_rate   [srr_pkg::NUM_SERVOS];
    logic [12:0] srv_cruise [srr_pkg::NUM_SERVOS];
    logic [7:0]  slice_cfg;

    t_cmd_beat beats_to_send[$];
    t_move     moves_due[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  stall_order   = 0;
    int  stall_seen    = 0;
    int  hold_cnt      = 0;
    int  err_count     = 0;
    int  beats_taken   = 0;
    int  ignored_beats = 0;
    int  moves_checked = 0;
    int  arrivals      = 0;
    int  live_queued   = 0;
    int  slice_writes  = 0;
    bit  req_fire      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 600000);
        $display("Verification failed");
        $finish;
    end

    // predict the effect of one accepted command beat
    function automatic void predict_beat(input t_cmd_beat b);
        int          s;
        logic [15:0] ang;
        logic [15:0] here;
        logic [15:0] goal;
        logic [9:0]  dps;
        logic [16:0] fac;
        logic [31:0] grown;
        logic [31:0] limit;
        logic [31:0] gap;
        logic [63:0] scaled;
        beats_taken++;
        if (b.id >= srr_pkg::NUM_SERVOS) begin
            ignored_beats++;
            return;
        end
        s = b.id;
        here = srv_pos[s];
        goal = srv_goal[s];
        if (b.cmd == srr_pkg::CMD_SET) begin
            ang = (b.angle > srr_pkg::ANGLE_MAX) ? srr_pkg::ANGLE_MAX : b.angle;
            dps = b.dps;
            if (dps < 10'(srr_pkg::DPS_MIN)) begin
                dps = 10'(srr_pkg::DPS_MIN);
            end else if (dps > 10'(srr_pkg::DPS_MAX)) begin
                dps = 10'(srr_pkg::DPS_MAX);
            end
            if (ang == here) return;
            if ((here > goal) != (here > ang)) srv_factor[s] = '0;
            srv_goal[s]   = ang;
            srv_rate[s]   = b.raise;
            srv_cruise[s] = 13'((32'(dps) * 32'd256) / 32'd10);
            return;
        end
        if (here == goal) return;
        fac = srv_factor[s];
        if (fac < srr_pkg::FACTOR_ONE) begin
            grown = 32'(fac) + 32'(srv_rate[s]) * 32'(slice_cfg);
            fac = (grown > 32'(srr_pkg::FACTOR_ONE)) ? srr_pkg::FACTOR_ONE : grown[16:0];
            srv_factor[s] = fac;
        end
        scaled = (64'(srv_cruise[s]) * 64'(fac) * 64'(fac)) >> 32;
        limit  = 32'((scaled * 64'(slice_cfg)) >> 8);
        gap    = (goal > here) ? 32'(goal - here) : 32'(here - goal);
        if (limit < gap) gap = limit;
        if (gap < 32'd1) gap = 32'd1;
        here = (goal < here) ? here - gap[15:0] : here + gap[15:0];
        srv_pos[s] = here;
        if (here == goal) begin
            srv_factor[s] = '0;
            arrivals++;
        end
        moves_due.push_back('{id: b.id, pos: here});
    endfunction

    always @(posedge i_clk) begin
        t_move want;
        req_fire = i_rst_n && req_ch.valid && req_ch.ready;
        if (req_fire) begin
            predict_beat('{cmd: req_ch.cmd, id: req_ch.servo_id, angle: req_ch.target_angle,
                           dps: req_ch.speed_dps, raise: req_ch.ramp_step});
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (moves_due.size() == 0) begin
                $error("move beat with none pending: servo_id_res %0d position %0d",
                       res_ch.servo_id_res, res_ch.position);
                err_count++;
            end else begin
                want = moves_due.pop_front();
                moves_checked++;
                if (res_ch.servo_id_res !== want.id) begin
                    $error("servo_id_res: expected %0d, got %0d", want.id, res_ch.servo_id_res);
                    err_count++;
                end
                if (res_ch.position !== want.pos) begin
                    $error("position: expected %0d, got %0d", want.pos, res_ch.position);
                    err_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        t_cmd_beat b;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_fire) begin
            if (beats_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                b = beats_to_send.pop_front();
                req_ch.cmd          <= b.cmd;
                req_ch.servo_id     <= b.id;
                req_ch.target_angle <= b.angle;
                req_ch.speed_dps    <= b.dps;
                req_ch.ramp_step    <= b.raise;
                req_ch.valid        <= 1'b1;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_seen != stall_order) begin
            stall_seen = stall_order;
            hold_cnt   = 90;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic void queue_beat(input logic c, input logic [7:0] id,
                                       input logic [15:0] ang, input logic [9:0] dps,
                                       input logic [15:0] raise);
        beats_to_send.push_back('{cmd: c, id: id, angle: ang, dps: dps, raise: raise});
        if (id < srr_pkg::NUM_SERVOS) live_queued++;
    endfunction

    task automatic wait_sent();
        while (beats_to_send.size() != 0 || req_ch.valid) @(posedge i_clk);
    endtask

    task automatic wait_quiet();
        wait_sent();
        while (moves_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_slice(input logic [7:0] value);
        wait_quiet();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * srr_pkg::REG_SLICE);
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        slice_cfg = value;
        slice_writes++;
    endtask

    initial begin
        int          phase;
        int          goal_cnt;
        int          s;
        int          k;
        int          delta;
        logic [15:0] ang;
        logic [15:0] here;
        logic [7:0]  slices [6];
        int          guard;
        bit          held;

        req_ch.valid        = 1'b0;
        req_ch.cmd          = srr_pkg::CMD_SET;
        req_ch.servo_id     = '0;
        req_ch.target_angle = '0;
        req_ch.speed_dps    = '0;
        req_ch.ramp_step    = '0;
        res_ch.ready        = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;
        for (int i = 0; i < srr_pkg::NUM_SERVOS; i++) begin
            srv_pos[i]    = '0;
            srv_goal[i]   = '0;
            srv_factor[i] = '0;
            srv_rate[i]   = '0;
            srv_cruise[i] = '0;
        end
        slice_cfg = srr_pkg::SLICE_RST;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: rest, ignored set, saturation, clamps, out of range, reversal, arrival
        queue_beat(srr_pkg::CMD_TICK, 8'd0, 16'd0, 10'd0, 16'd0);
        queue_beat(srr_pkg::CMD_SET, 8'd0, 16'd0, 10'd5, 16'd100);
        queue_beat(srr_pkg::CMD_SET, 8'd0, 16'hFFFF, 10'h3FF, 16'hFFFF);
        repeat (3) queue_beat(srr_pkg::CMD_TICK, 8'd0, 16'd0, 10'd0, 16'd0);
        queue_beat(srr_pkg::CMD_SET, 8'd1, 16'd100, 10'd0, 16'd0);
        repeat (2) queue_beat(srr_pkg::CMD_TICK, 8'd1, 16'hFFFF, 10'h3FF, 16'hFFFF);
        queue_beat(srr_pkg::CMD_SET, 8'd255, 16'd500, 10'd100, 16'd1000);
        queue_beat(srr_pkg::CMD_TICK, 8'd255, 16'd0, 10'd0, 16'd0);
        queue_beat(srr_pkg::CMD_TICK, 8'(srr_pkg::NUM_SERVOS), 16'd0, 10'd0, 16'd0);
        queue_beat(srr_pkg::CMD_SET, 8'd0, 16'd0, 10'd240, 16'd3000);
        repeat (2) queue_beat(srr_pkg::CMD_TICK, 8'd0, 16'd0, 10'd0, 16'd0);
        queue_beat(srr_pkg::CMD_SET, 8'd2, 16'd5, 10'd240, 16'hFFFF);
        repeat (2) queue_beat(srr_pkg::CMD_TICK, 8'd2, 16'd0, 10'd0, 16'd0);
        queue_beat(srr_pkg::CMD_SET, 8'd7, 16'd36000, 10'd123, 16'h8000);
        queue_beat(srr_pkg::CMD_SET, 8'd7, 16'd36001, 10'd241, 16'h0001);
        repeat (2) queue_beat(srr_pkg::CMD_TICK, 8'd7, 16'd0, 10'd0, 16'd0);
        queue_beat(srr_pkg::CMD_SET, 8'd6, 16'd20, 10'd1, 16'd1);
        queue_beat(srr_pkg::CMD_TICK, 8'd6, 16'd0, 10'd0, 16'd0);

        slices[0] = 8'd255;
        slices[1] = 8'd1;
        slices[2] = 8'd0;
        slices[3] = 8'($urandom_range(2, 254));
        slices[4] = srr_pkg::SLICE_RST;
        slices[5] = 8'($urandom_range(1, 255));

        for (phase = 0; phase < 6; phase++) begin
            set_slice(slices[phase]);
            if (phase < 2) begin
                send_idle_pct = 24;
                recv_idle_pct = 54;
            end else if (phase < 4) begin
                send_idle_pct = 54;
                recv_idle_pct = 24;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            goal_cnt = live_queued + 170;
            held = 1'b0;
            while (live_queued < goal_cnt) begin
                if (!held && live_queued > goal_cnt - 120) begin
                    // long receiver hold while a busy servo keeps ticking
                    held = 1'b1;
                    s = $urandom_range(0, srr_pkg::NUM_SERVOS - 1);
                    ang = (srv_pos[s] > 16'd18000) ? 16'd0 : srr_pkg::ANGLE_MAX;
                    queue_beat(srr_pkg::CMD_SET, 8'(s), ang, 10'd240, 16'hFFFF);
                    repeat (24) queue_beat(srr_pkg::CMD_TICK, 8'(s), 16'($urandom),
                                           10'($urandom), 16'($urandom));
                    stall_order++;
                    wait_sent();
                    while (moves_due.size() != 0) @(posedge i_clk);
                end else if ($urandom_range(0, 99) < 75) begin
                    s = $urandom_range(0, srr_pkg::NUM_SERVOS - 1);
                    here = srv_pos[s];
                    case ($urandom_range(0, 3))
                        0: ang = 16'($urandom);
                        1: ang = 16'($urandom_range(0, 36000));
                        2: begin
                            delta = $urandom_range(0, 60);
                            if ($urandom_range(0, 1) && here >= 16'(delta)) begin
                                ang = here - 16'(delta);
                            end else begin
                                ang = here + 16'(delta);
                            end
                        end
                        default: ang = $urandom_range(0, 1) ? srr_pkg::ANGLE_MAX : 16'd0;
                    endcase
                    queue_beat(srr_pkg::CMD_SET, 8'(s), ang, 10'($urandom),
                               16'($urandom) >> $urandom_range(0, 15));
                    k = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(2, 16);
                    repeat (k) queue_beat(srr_pkg::CMD_TICK, 8'(s), 16'($urandom),
                                          10'($urandom), 16'($urandom));
                    wait_sent();
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        queue_beat(1'($urandom), ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                   : 8'($urandom_range(0, srr_pkg::NUM_SERVOS - 1)),
                                   16'($urandom), 10'($urandom), 16'($urandom));
                    end
                end
            end
        end

        wait_sent();
        guard = 0;
        while (moves_due.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (moves_due.size() != 0) begin
            $error("%0d move beats never arrived", moves_due.size());
            err_count++;
        end
        $display("Run: %0d command beats (%0d out of range), %0d slice writes incl. 0, 1, 255.",
                 beats_taken, ignored_beats, slice_writes);
        $display("Run: %0d move beats checked, %0d arrivals, %0d mismatches.",
                 moves_checked, arrivals, err_count);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
